FILE: hdl/csfh_pkg.sv
// Shared types, constants and a helper function for the content store block.
`default_nettype none
package csfh_pkg;

	// Table geometry
	localparam int BUCKETS    = 1024;
	localparam int WAYS       = 4;
	localparam int MAX_CAP    = 1024;
	localparam int NAME_BYTES = 32;
	localparam int NAME_WORDS = 4;
	localparam int RING_SIZE  = MAX_CAP + 1;

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int WAY_W  = $clog2(WAYS);
	localparam int RIDX_W = $clog2(RING_SIZE);
	localparam int LEN_W  = 6;
	localparam int CFG_W  = 11;

	// Register indexes on the configuration port
	localparam int REG_BUCKET_COUNT = 0;
	localparam int REG_CAPACITY     = 1;

	typedef enum logic [2:0] {
		ST_INSERTED    = 3'd0,
		ST_BUCKET_FULL = 3'd1,
		ST_HIT         = 3'd2,
		ST_MISS        = 3'd3,
		ST_TOO_LONG    = 3'd4
	} status_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic                             insert;
		logic                             too_long;
		logic [BKT_W-1:0]                 bucket;
		logic [31:0]                      hash;
		logic [LEN_W-1:0]                 len;
		logic [NAME_WORDS-1:0][63:0]      words;
		logic [31:0]                      handle;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] found_handle;
		logic        evicted_valid;
		logic [31:0] evicted_handle;
	} result_t;

	// One bucket row of the slot table
	typedef struct packed {
		logic [WAYS-1:0]             busy;
		logic [WAYS-1:0][31:0]       hash;
		logic [WAYS-1:0][RIDX_W-1:0] ridx;
	} row_t;

	// One ring position
	typedef struct packed {
		logic [BKT_W-1:0]            bucket;
		logic [WAY_W-1:0]            way;
		logic [LEN_W-1:0]            len;
		logic [NAME_WORDS-1:0][63:0] words;
		logic [31:0]                 handle;
	} ring_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_ROW, B_LK, B_LKCMP, B_EV, B_EVROW, B_INSRD, B_INS, B_DONE
	} back_state_t;

	// Keeps only the bytes of name word w that lie below len.
	function automatic logic [63:0] mask_word(input logic [63:0] word, input logic [1:0] w,
			input logic [LEN_W-1:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if ({1'b0, w, 3'(b)} < len) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return word & m;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/content_store_fifo_hash_core.sv
// Top level of the content store: configuration registers, front end, queue and back end.
//
//  Channel  | Direction | Beat contents
//  s_axis   | in        | tuser: opcode; tdata: hash, name_length, name words 0-3, handle
//  m_axis   | out       | tuser: status; tdata: found_handle, evicted_valid, evicted_handle
//  APB      | in/out    | bucket_count at 0x0, capacity at 0x4
//
// The front end accepts a beat and then finds the bucket, one remainder bit per cycle; it
// takes no new beat until the item is in the queue, and a name that is too long skips
// the bucket search.
// The back end handles one item at a time, paced by the single read port of each memory.
// After reset, and after every capacity write, a clearing pass goes through every row of
// the slot table; items wait in the queue meanwhile.
// A stalled result waits in the output register while the next items are worked on.
`default_nettype none
module content_store_fifo_hash_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [327:0] s_axis_tdata,  // hash, name_length, name_word_0..3, handle
	input  wire logic         s_axis_tuser,  // opcode
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata,  // found_handle, evicted_valid, evicted_handle
	output logic [2:0]        m_axis_tuser,  // status
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CFG_W = csfh_pkg::CFG_W;

	logic [CFG_W-1:0]   bucket_count_q, capacity_q, wval;
	logic               wr_en, flush;
	logic               q_push, q_full, q_pop, q_empty;
	csfh_pkg::item_t    f_item, q_head;
	csfh_pkg::result_t  res;

	// Configuration registers, stored at their clamped values
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wval   = pwdata[CFG_W-1:0];
	assign flush  = wr_en && paddr == 3'(4 * csfh_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_W'(csfh_pkg::BUCKETS);
			capacity_q     <= CFG_W'(csfh_pkg::MAX_CAP);
		end else if (wr_en) begin
			if (paddr == 3'(4 * csfh_pkg::REG_BUCKET_COUNT)) begin
				if (wval == '0) begin
					bucket_count_q <= CFG_W'(1);
				end else if (wval > CFG_W'(csfh_pkg::BUCKETS)) begin
					bucket_count_q <= CFG_W'(csfh_pkg::BUCKETS);
				end else begin
					bucket_count_q <= wval;
				end
			end else if (flush) begin
				if (wval == '0) begin
					capacity_q <= CFG_W'(1);
				end else if (wval > CFG_W'(csfh_pkg::MAX_CAP)) begin
					capacity_q <= CFG_W'(csfh_pkg::MAX_CAP);
				end else begin
					capacity_q <= wval;
				end
			end
		end
	end

	// Register read back
	always_comb begin
		prdata = '0;
		if (paddr == 3'(4 * csfh_pkg::REG_BUCKET_COUNT)) begin
			prdata = 32'(bucket_count_q);
		end else if (paddr == 3'(4 * csfh_pkg::REG_CAPACITY)) begin
			prdata = 32'(capacity_q);
		end
	end

	csfh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser),
		.in_data      (s_axis_tdata),
		.bucket_count (bucket_count_q),
		.q_push       (q_push),
		.q_item       (f_item),
		.q_full       (q_full)
	);

	csfh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_item (q_head),
		.empty     (q_empty)
	);

	csfh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.capacity   (capacity_q),
		.flush      (flush),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (res)
	);

	// Result beat packing
	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {7'd0, res.evicted_handle, res.evicted_valid, res.found_handle};

endmodule
`default_nettype wire

FILE: hdl/csfh_front.sv
// Front end: accepts beats, masks the name, flags long names and finds the bucket.
`default_nettype none
module csfh_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       in_op,
	input  wire logic [327:0]               in_data,
	input  wire logic [csfh_pkg::CFG_W-1:0] bucket_count,
	output logic                            q_push,
	output csfh_pkg::item_t                 q_item,
	input  wire logic                       q_full
);

	csfh_pkg::front_state_t st_q, st_d;
	csfh_pkg::item_t        item_q;
	logic [31:0]            dvd_q;
	logic [4:0]             cnt_q;
	logic [10:0]            trial;
	logic [csfh_pkg::BKT_W-1:0] rem_d;
	logic [csfh_pkg::LEN_W-1:0] len_in;

	assign len_in = in_data[37:32];

	// One remainder bit per cycle over the 32 hash bits
	always_comb begin
		trial = {item_q.bucket, dvd_q[31]};
		if (trial >= bucket_count) begin
			rem_d = csfh_pkg::BKT_W'(trial - bucket_count);
		end else begin
			rem_d = csfh_pkg::BKT_W'(trial);
		end
	end

	// Next state and handshakes
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		q_push   = 1'b0;
		case (st_q)
			csfh_pkg::F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					st_d = (len_in > csfh_pkg::LEN_W'(csfh_pkg::NAME_BYTES)) ?
						csfh_pkg::F_PUSH : csfh_pkg::F_DIV;
				end
			end
			csfh_pkg::F_DIV: begin
				if (cnt_q == 5'd31) begin
					st_d = csfh_pkg::F_PUSH;
				end
			end
			csfh_pkg::F_PUSH: begin
				q_push = !q_full;
				if (!q_full) begin
					st_d = csfh_pkg::F_IDLE;
				end
			end
			default: st_d = csfh_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= csfh_pkg::F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Item capture and the remainder datapath
	always_ff @(posedge clk) begin
		if (st_q == csfh_pkg::F_IDLE && in_valid) begin
			item_q.insert   <= in_op;
			item_q.too_long <= len_in > csfh_pkg::LEN_W'(csfh_pkg::NAME_BYTES);
			item_q.bucket   <= '0;
			item_q.hash     <= in_data[31:0];
			item_q.len      <= len_in;
			for (int k = 0; k < csfh_pkg::NAME_WORDS; k++) begin
				item_q.words[k] <= csfh_pkg::mask_word(in_data[38 + 64*k +: 64], 2'(k), len_in);
			end
			item_q.handle   <= in_data[325:294];
			dvd_q           <= in_data[31:0];
			cnt_q           <= '0;
		end else if (st_q == csfh_pkg::F_DIV) begin
			item_q.bucket <= rem_d;
			dvd_q         <= {dvd_q[30:0], 1'b0};
			cnt_q         <= cnt_q + 5'd1;
		end
	end

	assign q_item = item_q;

endmodule
`default_nettype wire

FILE: hdl/csfh_queue.sv
// Two-entry queue of classified items between the front and the back.
`default_nettype none
module csfh_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  csfh_pkg::item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output csfh_pkg::item_t head_item,
	output logic           empty
);

	csfh_pkg::item_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign empty     = count_q == 2'd0;
	assign head_item = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/csfh_back.sv
// Back end: slot table and ring memories, the insert and lookup sequencer, result register.
`default_nettype none
module csfh_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_empty,
	input  csfh_pkg::item_t                 q_item,
	output logic                            q_pop,
	input  wire logic [csfh_pkg::CFG_W-1:0] capacity,
	input  wire logic                       flush,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output csfh_pkg::result_t               out_result
);

	localparam int BKT_W  = csfh_pkg::BKT_W;
	localparam int RIDX_W = csfh_pkg::RIDX_W;
	localparam int WAY_W  = csfh_pkg::WAY_W;

	csfh_pkg::back_state_t st_q, st_d;
	csfh_pkg::item_t       item_q;
	csfh_pkg::result_t     res_q, out_q;
	logic                  out_valid_q;
	logic [WAY_W-1:0]      way_q, ev_way_q;
	logic [BKT_W-1:0]      ev_bkt_q;
	logic [BKT_W-1:0]      clr_cnt_q;
	logic [RIDX_W-1:0]     head_q, tail_q;

	// Memories
	csfh_pkg::row_t  row_mem [csfh_pkg::BUCKETS];
	csfh_pkg::ring_t ring_mem [csfh_pkg::RING_SIZE];
	csfh_pkg::row_t  row_rd_q, row_wdata;
	csfh_pkg::ring_t ring_rd_q, ring_wdata;
	logic             row_re, row_we, ring_re, ring_we;
	logic [BKT_W-1:0] row_raddr, row_waddr;
	logic [RIDX_W-1:0] ring_raddr;

	logic             free_found, ring_full, lk_cand, name_same;
	logic [WAY_W-1:0] free_way;
	logic [RIDX_W-1:0] head_next, tail_next;

	function automatic logic [RIDX_W-1:0] ring_next(input logic [RIDX_W-1:0] p,
			input logic [csfh_pkg::CFG_W-1:0] cap);
		logic [RIDX_W:0] n;
		n = {1'b0, p} + (RIDX_W+1)'(1);
		return (n >= ((RIDX_W+1)'(cap) + (RIDX_W+1)'(1))) ? '0 : n[RIDX_W-1:0];
	endfunction

	assign head_next = ring_next(head_q, capacity);
	assign tail_next = ring_next(tail_q, capacity);
	assign ring_full = head_next == tail_q;

	// First free way of the row just read
	always_comb begin
		free_found = 1'b0;
		free_way   = '0;
		for (int w = csfh_pkg::WAYS - 1; w >= 0; w--) begin
			if (!row_rd_q.busy[w]) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
		end
	end

	// Candidate way for a lookup, and the name comparison against the ring entry
	always_comb begin
		lk_cand = row_rd_q.busy[way_q] && row_rd_q.hash[way_q] == item_q.hash &&
			row_rd_q.ridx[way_q] <= RIDX_W'(csfh_pkg::RING_SIZE - 1);
		name_same = ring_rd_q.len == item_q.len;
		for (int k = 0; k < csfh_pkg::NAME_WORDS; k++) begin
			if (csfh_pkg::mask_word(ring_rd_q.words[k], 2'(k), item_q.len) != item_q.words[k]) begin
				name_same = 1'b0;
			end
		end
	end

	// Next state and memory controls
	always_comb begin
		st_d       = st_q;
		q_pop      = 1'b0;
		row_re     = 1'b0;
		row_raddr  = item_q.bucket;
		row_we     = 1'b0;
		row_waddr  = item_q.bucket;
		row_wdata  = row_rd_q;
		ring_re    = 1'b0;
		ring_raddr = tail_q;
		ring_we    = 1'b0;
		ring_wdata.bucket = item_q.bucket;
		ring_wdata.way    = way_q;
		ring_wdata.len    = item_q.len;
		ring_wdata.words  = item_q.words;
		ring_wdata.handle = item_q.handle;
		case (st_q)
			csfh_pkg::B_CLEAR: begin
				row_we         = 1'b1;
				row_waddr      = clr_cnt_q;
				row_wdata.busy = '0;
				if (clr_cnt_q == BKT_W'(csfh_pkg::BUCKETS - 1)) begin
					st_d = csfh_pkg::B_IDLE;
				end
			end
			csfh_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_item.too_long) begin
						st_d = csfh_pkg::B_DONE;
					end else begin
						row_re    = 1'b1;
						row_raddr = q_item.bucket;
						st_d      = csfh_pkg::B_ROW;
					end
				end
			end
			csfh_pkg::B_ROW: begin
				if (!item_q.insert) begin
					st_d = csfh_pkg::B_LK;
				end else if (!free_found) begin
					st_d = csfh_pkg::B_DONE;
				end else if (ring_full) begin
					ring_re = 1'b1;
					st_d    = csfh_pkg::B_EV;
				end else begin
					st_d = csfh_pkg::B_INS;
				end
			end
			csfh_pkg::B_LK: begin
				if (lk_cand) begin
					ring_re    = 1'b1;
					ring_raddr = row_rd_q.ridx[way_q];
					st_d       = csfh_pkg::B_LKCMP;
				end else if (way_q == WAY_W'(csfh_pkg::WAYS - 1)) begin
					st_d = csfh_pkg::B_DONE;
				end
			end
			csfh_pkg::B_LKCMP: begin
				if (name_same || way_q == WAY_W'(csfh_pkg::WAYS - 1)) begin
					st_d = csfh_pkg::B_DONE;
				end else begin
					st_d = csfh_pkg::B_LK;
				end
			end
			csfh_pkg::B_EV: begin
				row_re    = 1'b1;
				row_raddr = ring_rd_q.bucket;
				st_d      = csfh_pkg::B_EVROW;
			end
			csfh_pkg::B_EVROW: begin
				row_we                   = 1'b1;
				row_waddr                = ev_bkt_q;
				row_wdata.busy[ev_way_q] = 1'b0;
				st_d                     = csfh_pkg::B_INSRD;
			end
			csfh_pkg::B_INSRD: begin
				row_re = 1'b1;
				st_d   = csfh_pkg::B_INS;
			end
			csfh_pkg::B_INS: begin
				row_we                = 1'b1;
				row_wdata.busy[way_q] = 1'b1;
				row_wdata.hash[way_q] = item_q.hash;
				row_wdata.ridx[way_q] = head_q;
				ring_we               = 1'b1;
				st_d                  = csfh_pkg::B_DONE;
			end
			csfh_pkg::B_DONE: begin
				if (!out_valid_q || out_ready) begin
					st_d = csfh_pkg::B_IDLE;
				end
			end
			default: st_d = csfh_pkg::B_IDLE;
		endcase
		if (flush) begin
			st_d = csfh_pkg::B_CLEAR;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= csfh_pkg::B_CLEAR;
			clr_cnt_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (flush) begin
				clr_cnt_q <= '0;
				head_q    <= '0;
				tail_q    <= '0;
			end else begin
				if (st_q == csfh_pkg::B_CLEAR) begin
					clr_cnt_q <= clr_cnt_q + BKT_W'(1);
				end
				if (st_q == csfh_pkg::B_EV) begin
					tail_q <= tail_next;
				end
				if (st_q == csfh_pkg::B_INS) begin
					head_q <= head_next;
				end
			end
			if (st_q == csfh_pkg::B_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, way and result registers
	always_ff @(posedge clk) begin
		case (st_q)
			csfh_pkg::B_IDLE: begin
				item_q <= q_item;
				way_q  <= '0;
				res_q.status <= q_item.too_long ? csfh_pkg::ST_TOO_LONG : csfh_pkg::ST_MISS;
				res_q.found_handle   <= '0;
				res_q.evicted_valid  <= 1'b0;
				res_q.evicted_handle <= '0;
			end
			csfh_pkg::B_ROW: begin
				if (item_q.insert) begin
					way_q        <= free_way;
					res_q.status <= free_found ? csfh_pkg::ST_INSERTED : csfh_pkg::ST_BUCKET_FULL;
				end
			end
			csfh_pkg::B_LK: begin
				if (!lk_cand && way_q != WAY_W'(csfh_pkg::WAYS - 1)) begin
					way_q <= way_q + WAY_W'(1);
				end
			end
			csfh_pkg::B_LKCMP: begin
				if (name_same) begin
					res_q.status       <= csfh_pkg::ST_HIT;
					res_q.found_handle <= ring_rd_q.handle;
				end else if (way_q != WAY_W'(csfh_pkg::WAYS - 1)) begin
					way_q <= way_q + WAY_W'(1);
				end
			end
			csfh_pkg::B_EV: begin
				res_q.evicted_valid  <= 1'b1;
				res_q.evicted_handle <= ring_rd_q.handle;
				ev_bkt_q             <= ring_rd_q.bucket;
				ev_way_q             <= ring_rd_q.way;
			end
			csfh_pkg::B_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// Slot table memory, one bucket row per address
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (row_re) begin
			row_rd_q <= row_mem[row_raddr];
		end
	end

	// Ring memory, written at the head and read at the tail or a slot's position
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[head_q] <= ring_wdata;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[ring_raddr];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule
`default_nettype wire

FILE: tb/content_store_fifo_hash_core_checker.sv
// Checker for the content store: predicts every result beat and compares it with the block.
`timescale 1ns / 100ps
module content_store_fifo_hash_core_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [327:0] s_axis_tdata,  // hash, name_length, name_word_0..3, handle
	input  wire logic         s_axis_tuser,  // opcode
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [71:0]  m_axis_tdata,  // found_handle, evicted_valid, evicted_handle
	input  wire logic [2:0]   m_axis_tuser,  // status
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	input  wire logic         pready,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);

	// Shadow copy of the table, the ring and the registers
	bit          slot_busy [csfh_pkg::BUCKETS*csfh_pkg::WAYS];
	bit [31:0]   slot_hash [csfh_pkg::BUCKETS*csfh_pkg::WAYS];
	bit [10:0]   slot_ridx [csfh_pkg::BUCKETS*csfh_pkg::WAYS];
	bit [9:0]    ring_bkt [csfh_pkg::RING_SIZE];
	bit [1:0]    ring_way [csfh_pkg::RING_SIZE];
	bit [5:0]    ring_len [csfh_pkg::RING_SIZE];
	bit [255:0]  ring_name [csfh_pkg::RING_SIZE];
	bit [31:0]   ring_hdl [csfh_pkg::RING_SIZE];
	int unsigned head, tail, bucket_cnt, cap;
	csfh_pkg::result_t expected_results [$];

	function automatic int unsigned clamp_cfg(bit [10:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic int unsigned ring_step(int unsigned p);
		return (p + 1 >= cap + 1) ? 0 : p + 1;
	endfunction

	function automatic void flush_table();
		foreach (slot_busy[i]) slot_busy[i] = 1'b0;
		head = 0;
		tail = 0;
	endfunction

	// Works out the result of one item and updates the shadow state.
	function automatic csfh_pkg::result_t cache_access(bit op, bit [31:0] h, bit [5:0] len,
			bit [255:0] raw, bit [31:0] hdl);
		csfh_pkg::result_t res;
		bit [255:0]  m;
		bit [255:0]  nm;
		int unsigned bkt, s, t, es, r;
		res = '0;
		if (len > csfh_pkg::NAME_BYTES) begin
			res.status = csfh_pkg::ST_TOO_LONG;
			return res;
		end
		m = '1;
		if (len < 32) m = (256'd1 << (8 * len)) - 256'd1;
		nm = raw & m;
		bkt = h % bucket_cnt;
		if (op) begin
			for (int w = 0; w < csfh_pkg::WAYS; w++) begin
				s = bkt * csfh_pkg::WAYS + w;
				if (slot_busy[s]) continue;
				// A full ring gives up its oldest entry first.
				if (ring_step(head) == tail) begin
					t = tail;
					es = ring_bkt[t] * csfh_pkg::WAYS + ring_way[t];
					slot_busy[es] = 1'b0;
					res.evicted_valid = 1'b1;
					res.evicted_handle = ring_hdl[t];
					tail = ring_step(t);
				end
				slot_busy[s] = 1'b1;
				slot_hash[s] = h;
				slot_ridx[s] = 11'(head);
				ring_bkt[head] = 10'(bkt);
				ring_way[head] = 2'(w);
				ring_len[head] = len;
				ring_name[head] = nm;
				ring_hdl[head] = hdl;
				head = ring_step(head);
				res.status = csfh_pkg::ST_INSERTED;
				return res;
			end
			res.status = csfh_pkg::ST_BUCKET_FULL;
			return res;
		end
		for (int w = 0; w < csfh_pkg::WAYS; w++) begin
			s = bkt * csfh_pkg::WAYS + w;
			if (!slot_busy[s] || slot_hash[s] != h) continue;
			r = 32'(slot_ridx[s]);
			if (ring_len[r] != len || ring_name[r] != nm) continue;
			res.status = csfh_pkg::ST_HIT;
			res.found_handle = ring_hdl[r];
			return res;
		end
		res.status = csfh_pkg::ST_MISS;
		return res;
	endfunction

	assign outstanding = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		csfh_pkg::result_t exp_res;
		csfh_pkg::result_t got;
		int unsigned       errs;
		if (!arst_n) begin
			bucket_cnt = csfh_pkg::BUCKETS;
			cap = csfh_pkg::MAX_CAP;
			flush_table();
			expected_results.delete();
			mismatches <= 0;
		end else begin
			errs = 0;
			// Register writes are only made while the block is idle.
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == csfh_pkg::REG_BUCKET_COUNT) begin
					bucket_cnt = clamp_cfg(pwdata[10:0], csfh_pkg::BUCKETS);
				end else begin
					cap = clamp_cfg(pwdata[10:0], csfh_pkg::MAX_CAP);
					flush_table();
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(cache_access(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[37:32], s_axis_tdata[293:38], s_axis_tdata[325:294]));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = csfh_pkg::status_t'(m_axis_tuser);
				got.found_handle = m_axis_tdata[31:0];
				got.evicted_valid = m_axis_tdata[32];
				got.evicted_handle = m_axis_tdata[64:33];
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: status %0d", m_axis_tuser);
					errs++;
				end else begin
					exp_res = expected_results.pop_front();
					if (got.status != exp_res.status) begin
						$error("status: expected %0d, actual %0d", exp_res.status, got.status);
						errs++;
					end
					if (got.found_handle != exp_res.found_handle) begin
						$error("found_handle: expected %h, actual %h", exp_res.found_handle,
							got.found_handle);
						errs++;
					end
					if (got.evicted_valid != exp_res.evicted_valid) begin
						$error("evicted_valid: expected %0d, actual %0d", exp_res.evicted_valid,
							got.evicted_valid);
						errs++;
					end
					if (got.evicted_handle != exp_res.evicted_handle) begin
						$error("evicted_handle: expected %h, actual %h", exp_res.evicted_handle,
							got.evicted_handle);
						errs++;
					end
				end
			end
			if (errs != 0) begin
				mismatches <= mismatches + errs;
			end
		end
	end

endmodule

FILE: tb/content_store_fifo_hash_core_test.sv
// Testbench top for the content store: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps
module content_store_fifo_hash_core_test;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [327:0] s_axis_tdata = '0;  // hash, name_length, name_word_0..3, handle
	logic         s_axis_tuser = 1'b0;  // opcode
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [71:0]  m_axis_tdata;  // found_handle, evicted_valid, evicted_handle
	logic [2:0]   m_axis_tuser;  // status
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int unsigned  mismatches;
	int unsigned  outstanding;

	// Pool of names that the random part keeps inserting and looking up
	bit [31:0]  key_hash [16];
	bit [5:0]   key_len [16];
	bit [255:0] key_name [16];

	content_store_fifo_hash_core u_dut (.*);

	content_store_fifo_hash_core_checker u_checker (.*);

	always #4 clk = ~clk;

	// Sends one beat and waits for it to be taken, then sometimes idles for a random gap.
	task automatic send_beat(bit op, bit [31:0] h, bit [5:0] len, bit [255:0] nm,
			bit [31:0] hdl);
		int r;
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {2'b00, hdl, nm, len, h};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		r = $urandom_range(0, 99);
		if (r >= 65) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 328'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom});
			repeat (r >= 95 ? $urandom_range(10, 60) : $urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// Writes a register once the block has returned every result.
	task automatic write_reg(int idx, bit [31:0] val);
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = 3'(idx * 4);
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic bit [255:0] rand_name();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic void new_key(int k);
		key_hash[k] = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 7) : $urandom;
		key_len[k] = 6'($urandom_range(0, 32));
		key_name[k] = rand_name();
	endfunction

	// One random item: mostly inserts and lookups of known names, some noise.
	task automatic random_item();
		int         r;
		int         k;
		int         pos;
		bit [255:0] nm;
		bit [5:0]   len;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 15);
		nm = key_name[k];
		len = key_len[k];
		if (r < 40) begin
			send_beat(1'b1, key_hash[k], len, nm, $urandom);
		end else if (r < 85) begin
			// Lookups sometimes disturb the name, inside or beyond its length.
			case ($urandom_range(0, 5))
				0: if (len < 32) begin
					pos = $urandom_range(len, 31);
					nm[pos*8 +: 8] = 8'($urandom);
				end
				1: if (len > 0) begin
					pos = $urandom_range(0, len - 1);
					nm[pos*8 +: 8] = ~nm[pos*8 +: 8];
				end
				2: len = 6'($urandom_range(0, 32));
				default: ;
			endcase
			send_beat(1'b0, key_hash[k], len, nm, $urandom);
		end else if (r < 93) begin
			new_key(k);
			send_beat(1'b1, key_hash[k], key_len[k], key_name[k], $urandom);
		end else begin
			send_beat(1'($urandom_range(0, 1)), $urandom, 6'($urandom_range(0, 63)),
				rand_name(), $urandom);
		end
	endtask

	// Result side stalls: stretches of readiness broken by gaps, now and then long ones.
	initial begin
		forever begin
			m_axis_tready = 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			if ($urandom_range(0, 3) != 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(15, 80) : $urandom_range(1, 4))
					@(negedge clk);
			end
		end
	end

	initial begin
		bit [31:0] bc_set [7] = '{4, 2047, 1, 0, 16, 1000, 2};
		bit [31:0] cap_set [7] = '{6, 1024, 3, 0, 40, 2000, 1024};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset configuration
		send_beat(1'b0, 32'h0, 6'd33, '1, 32'h0);
		send_beat(1'b1, 32'hFFFF_FFFF, 6'd63, '1, 32'hFFFF_FFFF);
		send_beat(1'b0, 32'h1234, 6'd5, rand_name(), 32'h0);
		send_beat(1'b1, 32'h0, 6'd0, rand_name(), 32'h0);
		send_beat(1'b0, 32'h0, 6'd0, rand_name(), 32'h0);
		send_beat(1'b1, 32'hFFFF_FFFF, 6'd32, '1, 32'hFFFF_FFFF);
		send_beat(1'b0, 32'hFFFF_FFFF, 6'd32, '1, 32'h0);
		send_beat(1'b1, 32'h55, 6'd3, 256'hAABBCC, 32'h1111);
		send_beat(1'b0, 32'h55, 6'd3, {253'h7F, 3'b0} << 24 | 256'hAABBCC, 32'h0);
		send_beat(1'b0, 32'h55, 6'd3, 256'hAABBCD, 32'h0);
		send_beat(1'b0, 32'h55, 6'd4, 256'hAABBCC, 32'h0);

		// One bucket only: the fifth insert finds its bucket full.
		write_reg(csfh_pkg::REG_BUCKET_COUNT, 32'd1);
		write_reg(csfh_pkg::REG_CAPACITY, 32'hFFFF_F7FF);
		for (int i = 0; i < 5; i++) send_beat(1'b1, $urandom, 6'd8, rand_name(), i);

		// A ring of one entry evicts on every further insert.
		write_reg(csfh_pkg::REG_CAPACITY, 32'd0);
		for (int i = 0; i < 3; i++) send_beat(1'b1, i, 6'd1, 256'h41, 32'hA0 + i);
		send_beat(1'b0, 32'd2, 6'd1, 256'h41, 32'h0);

		// Random part over several settings
		for (int k = 0; k < 16; k++) new_key(k);
		for (int p = 0; p < 7; p++) begin
			write_reg(csfh_pkg::REG_BUCKET_COUNT, bc_set[p] | ($urandom & 32'hFFFF_F800));
			if (p != 6) begin
				write_reg(csfh_pkg::REG_CAPACITY, cap_set[p] | ($urandom & 32'hFFFF_F800));
			end
			repeat (175) random_item();
		end

		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("[content_store_fifo_hash_core] OK");
		end else begin
			$display("[content_store_fifo_hash_core] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[content_store_fifo_hash_core] ERROR");
		$finish;
	end

endmodule
